// File: src/lspd_pkg.sv
// Shared constants, types and codes for the line-sensor PD motor drive.
// No dependencies; every other file of the block imports this package.
package lspd_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int N_LANES     = 8;
    localparam int W_BITS      = 6;
    localparam int GAIN_BITS   = 8;
    localparam int SPEED_BITS  = 11;
    localparam int CFG_BITS    = 11;
    localparam int CFG_IDX_W   = 2;

    localparam int DUTY_MAX    = 1000;
    localparam int DUTY_W      = 10;
    localparam int DIR_W       = 2;

    localparam int ERR_W       = 10;
    localparam int CORR_W      = 19;
    localparam int CMD_W       = 20;
    localparam int TERM_W      = 10;
    localparam int SUM_W       = 11;
    localparam int CNT_W       = 3;
    localparam int CAL_W       = SAMPLE_BITS + 3;

    // line error divider: two quotient bits per cycle
    localparam int DIV_W       = SUM_W;
    localparam int DIV_STEPS   = (DIV_W + 1) / 2;
    localparam int DIV_PW      = 2 * DIV_STEPS;
    localparam int DIV_CW      = $clog2(DIV_STEPS + 1);

    localparam int THR_RESET   = 2800;
    localparam int CAL_DIVISOR = 6;
    // side mean by reciprocal multiply, exact over the whole sample total range
    localparam int CAL_SHIFT   = 18;
    localparam int CAL_RECIP   = ((1 << CAL_SHIFT) + CAL_DIVISOR - 1) / CAL_DIVISOR;
    localparam int CAL_RECIP_W = 16;
    localparam int CAL_PROD_W  = CAL_W + CAL_RECIP_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SENS_WGT   = 2'd3;

    // motor direction codes
    localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

    typedef logic        [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [ERR_W-1:0]       t_err;
    typedef logic signed [TERM_W-1:0]      t_term;
    typedef logic signed [3:0]             t_pos;

    typedef struct packed {
        logic mul;   // register the two gain products
        logic cmd;   // register correction and motor commands
    } t_pd_ctrl;

    // position weight of each sensor; the centre sensor carries none
    localparam t_pos POS_WEIGHT [N_LANES] = '{
        -4'sd4, -4'sd3, -4'sd2, 4'sd0, 4'sd1, 4'sd2, 4'sd3, 4'sd4
    };
    // sensors that take part in the line position (bit i for sensor i)
    localparam logic [N_LANES-1:0] LANE_COUNTED = 8'b1111_0111;
    // sensors averaged against the centre one on calibration
    localparam logic [N_LANES-1:0] LANE_CAL     = 8'b1110_0111;

endpackage

// File: src/line_sensor_pd_motor_drive.sv
// Line-sensor PD motor drive, top level: input capture, sequencer, lanes,
// merge, divider, PD stage and output register. Depends on lspd_pkg.
//
// One item is taken at a time. A control beat with at least one sensor on
// the line passes the lane, merge, divider start, divider wait, error,
// multiply, command and output states; the count divider takes DIV_STEPS
// (6) steps at two quotient bits a cycle, and the quotient is handed over
// once it drops busy. A control beat that sees no line skips the divider.
// A calibrate beat forms the side mean with a reciprocal multiply and skips
// the divider and the PD stage. A result that is not taken holds the
// sequencer before its load; the next beat is accepted from the cycle after
// the result is loaded, even while that result has not yet been taken.
module line_sensor_pd_motor_drive (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [lspd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [lspd_pkg::CFG_BITS-1:0]          i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_func,
    input  lspd_pkg::t_sample                      i_sample_0,
    input  lspd_pkg::t_sample                      i_sample_1,
    input  lspd_pkg::t_sample                      i_sample_2,
    input  lspd_pkg::t_sample                      i_sample_3,
    input  lspd_pkg::t_sample                      i_sample_4,
    input  lspd_pkg::t_sample                      i_sample_5,
    input  lspd_pkg::t_sample                      i_sample_6,
    input  lspd_pkg::t_sample                      i_sample_7,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output lspd_pkg::t_err                         o_line_error,
    output logic signed [lspd_pkg::CORR_W-1:0]     o_correction,
    output logic [lspd_pkg::DUTY_W-1:0]            o_left_duty,
    output logic [lspd_pkg::DIR_W-1:0]             o_left_dir,
    output logic [lspd_pkg::DUTY_W-1:0]            o_right_duty,
    output logic [lspd_pkg::DIR_W-1:0]             o_right_dir,
    output lspd_pkg::t_sample                      o_threshold_now
);
    import lspd_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LANE  = 4'd1;
    localparam logic [3:0] S_MERGE = 4'd2;
    localparam logic [3:0] S_DIVS  = 4'd3;
    localparam logic [3:0] S_DIVW  = 4'd4;
    localparam logic [3:0] S_ERR   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_CMD   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    // configuration and architectural state
    logic [GAIN_BITS-1:0]         r_prop;
    logic [GAIN_BITS-1:0]         r_deriv;
    logic signed [SPEED_BITS-1:0] r_base;
    logic [W_BITS-1:0]            r_weight;
    t_err                         r_prev;
    t_sample                      r_thr;

    logic [3:0]                   r_state;
    logic [3:0]                   n_state;
    logic                         r_func;
    t_sample                      r_smp [N_LANES];
    t_sample                      w_smp [N_LANES];
    t_err                         r_err;
    t_sample                      r_thr_cal;

    logic                         w_lane_hit  [N_LANES];
    t_term                        w_lane_term [N_LANES];
    logic signed [SUM_W-1:0]      w_sum;
    logic [CNT_W-1:0]             w_cnt;
    logic [CAL_W-1:0]             w_cal;

    logic                         w_in_acc;
    logic                         w_div_start;
    logic                         w_div_busy;
    logic [DIV_W-1:0]             w_dividend;
    logic [CNT_W-1:0]             w_divisor;
    logic [DIV_W-1:0]             w_quot;
    logic [SUM_W-1:0]             w_abs;
    logic                         w_lost;

    logic [ERR_W-1:0]             w_w3u;
    logic [ERR_W-1:0]             w_w5u;
    t_err                         w_q_err;
    t_err                         n_err;
    logic [CAL_PROD_W-1:0]        w_cal_prod;
    t_sample                      w_cal_mean;
    logic signed [SAMPLE_BITS:0]  w_diff;
    t_sample                      n_thr_cal;

    t_pd_ctrl                     w_pd_ctrl;
    logic signed [CORR_W-1:0]     w_corr;
    logic [DUTY_W-1:0]            w_lduty;
    logic [DIR_W-1:0]             w_ldir;
    logic [DUTY_W-1:0]            w_rduty;
    logic [DIR_W-1:0]             w_rdir;

    logic                         w_out_load;
    logic                         r_out_valid;
    t_err                         r_o_err;
    logic signed [CORR_W-1:0]     r_o_corr;
    logic [DUTY_W-1:0]            r_o_lduty;
    logic [DIR_W-1:0]             r_o_ldir;
    logic [DUTY_W-1:0]            r_o_rduty;
    logic [DIR_W-1:0]             r_o_rdir;
    t_sample                      r_o_thr;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;

    assign w_smp[0] = i_sample_0;
    assign w_smp[1] = i_sample_1;
    assign w_smp[2] = i_sample_2;
    assign w_smp[3] = i_sample_3;
    assign w_smp[4] = i_sample_4;
    assign w_smp[5] = i_sample_5;
    assign w_smp[6] = i_sample_6;
    assign w_smp[7] = i_sample_7;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop   <= GAIN_BITS'(1);
            r_deriv  <= '0;
            r_base   <= SPEED_BITS'(100);
            r_weight <= W_BITS'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PROP_GAIN:  r_prop   <= i_cfg_data[GAIN_BITS-1:0];
                REG_DERIV_GAIN: r_deriv  <= i_cfg_data[GAIN_BITS-1:0];
                REG_BASE_SPEED: r_base   <= $signed(i_cfg_data[SPEED_BITS-1:0]);
                REG_SENS_WGT:   r_weight <= i_cfg_data[W_BITS-1:0];
                default: ;
            endcase
        end
    end

    // capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func <= i_func;
            for (int i = 0; i < N_LANES; i++) begin
                r_smp[i] <= w_smp[i];
            end
        end
    end

    for (genvar g = 0; g < N_LANES; g++) begin : g_lane
        lspd_lane u_lane (
            .i_clk     (i_clk),
            .i_load    (r_state == S_LANE),
            .i_sample  (r_smp[g]),
            .i_thr     (r_thr),
            .i_weight  (r_weight),
            .i_pos     (POS_WEIGHT[g]),
            .i_counted (LANE_COUNTED[g]),
            .o_hit     (w_lane_hit[g]),
            .o_term    (w_lane_term[g])
        );
    end

    lspd_merge u_merge (
        .i_clk  (i_clk),
        .i_load (r_state == S_MERGE),
        .i_hit  (w_lane_hit),
        .i_term (w_lane_term),
        .i_smp  (r_smp),
        .o_sum  (w_sum),
        .o_cnt  (w_cnt),
        .o_cal  (w_cal)
    );

    assign w_abs       = w_sum[SUM_W-1] ? SUM_W'(-w_sum) : SUM_W'(w_sum);
    assign w_lost      = !r_func && (w_cnt == '0);
    assign w_div_start = (r_state == S_DIVS) && !r_func && !w_lost;
    assign w_dividend  = DIV_W'(w_abs);
    assign w_divisor   = w_cnt;

    lspd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quot     (w_quot)
    );

    // line error: signed quotient, or the lost-line fallback
    assign w_w3u   = ERR_W'({4'b0, r_weight} * 3);
    assign w_w5u   = ERR_W'({4'b0, r_weight} * 5);
    assign w_q_err = t_err'(w_quot[ERR_W-1:0]);

    always_comb begin
        if (!w_lost) begin
            n_err = w_sum[SUM_W-1] ? t_err'(-w_q_err) : w_q_err;
        end else if (r_prev > $signed(w_w3u)) begin
            n_err = $signed(w_w5u);
        end else if (r_prev < t_err'(-$signed(w_w3u))) begin
            n_err = t_err'(-$signed(w_w5u));
        end else begin
            n_err = '0;
        end
    end

    // calibration threshold: half the centre excess over the side mean
    assign w_cal_prod = CAL_PROD_W'(w_cal) * CAL_PROD_W'(CAL_RECIP);
    assign w_cal_mean = w_cal_prod[CAL_SHIFT +: SAMPLE_BITS];
    assign w_diff     = $signed({1'b0, r_smp[3]}) - $signed({1'b0, w_cal_mean});
    assign n_thr_cal  = w_diff[SAMPLE_BITS] ? '0 : {1'b0, w_diff[SAMPLE_BITS-1:1]};

    always_ff @(posedge i_clk) begin
        if (r_state == S_ERR) begin
            r_err     <= n_err;
            r_thr_cal <= n_thr_cal;
        end
    end

    assign w_pd_ctrl.mul = (r_state == S_MUL);
    assign w_pd_ctrl.cmd = (r_state == S_CMD);

    lspd_pd u_pd (
        .i_clk        (i_clk),
        .i_ctrl       (w_pd_ctrl),
        .i_err        (r_err),
        .i_prev       (r_prev),
        .i_prop       (r_prop),
        .i_deriv      (r_deriv),
        .i_base       (r_base),
        .o_corr       (w_corr),
        .o_left_duty  (w_lduty),
        .o_left_dir   (w_ldir),
        .o_right_duty (w_rduty),
        .o_right_dir  (w_rdir)
    );

    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_LANE;
            S_LANE:  n_state = S_MERGE;
            S_MERGE: n_state = S_DIVS;
            S_DIVS:  n_state = (r_func || w_lost) ? S_ERR : S_DIVW;
            S_DIVW:  if (!w_div_busy) n_state = S_ERR;
            S_ERR:   n_state = r_func ? S_OUT : S_MUL;
            S_MUL:   n_state = S_CMD;
            S_CMD:   n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
            r_thr       <= SAMPLE_BITS'(THR_RESET);
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                if (r_func) begin
                    r_thr  <= r_thr_cal;
                end else begin
                    r_prev <= r_err;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result register; calibrate beats report a stopped drive
    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_func) begin
                r_o_err   <= '0;
                r_o_corr  <= '0;
                r_o_lduty <= '0;
                r_o_ldir  <= DIR_STOP;
                r_o_rduty <= '0;
                r_o_rdir  <= DIR_STOP;
                r_o_thr   <= r_thr_cal;
            end else begin
                r_o_err   <= r_err;
                r_o_corr  <= w_corr;
                r_o_lduty <= w_lduty;
                r_o_ldir  <= w_ldir;
                r_o_rduty <= w_rduty;
                r_o_rdir  <= w_rdir;
                r_o_thr   <= r_thr;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_error    = r_o_err;
    assign o_correction    = r_o_corr;
    assign o_left_duty     = r_o_lduty;
    assign o_left_dir      = r_o_ldir;
    assign o_right_duty    = r_o_rduty;
    assign o_right_dir     = r_o_rdir;
    assign o_threshold_now = r_o_thr;

    a_div_only_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> (r_state == S_DIVW))
        else $error("divider busy outside its wait state");

    a_cal_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && r_func) |=>
            (o_left_dir == DIR_STOP && o_right_dir == DIR_STOP && o_correction == '0))
        else $error("calibrate beat did not report a stopped drive");

    a_duty_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_duty <= DUTY_W'(DUTY_MAX) && o_right_duty <= DUTY_W'(DUTY_MAX)))
        else $error("duty above its limit");

    a_err_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && !r_func) |=>
            (o_line_error <= t_err'(315) && o_line_error >= t_err'(-315)))
        else $error("line error out of range");

    a_prev_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && !r_func) |=> (r_prev == o_line_error))
        else $error("previous error not updated from the delivered beat");

endmodule

// File: src/lspd_lane.sv
// One sensor lane: threshold compare and weighted position term.
// Depends on lspd_pkg.
module lspd_lane (
    input  logic                i_clk,
    input  logic                i_load,
    input  lspd_pkg::t_sample   i_sample,
    input  lspd_pkg::t_sample   i_thr,
    input  logic [lspd_pkg::W_BITS-1:0] i_weight,
    input  lspd_pkg::t_pos      i_pos,
    input  logic                i_counted,
    output logic                o_hit,
    output lspd_pkg::t_term     o_term
);
    import lspd_pkg::*;

    logic        w_hit;
    t_term       w_pos_x;
    t_term       w_wgt_x;
    t_term       w_term;
    logic        r_hit;
    t_term       r_term;

    assign w_hit   = i_counted && (i_sample > i_thr);
    assign w_pos_x = TERM_W'(i_pos);
    assign w_wgt_x = $signed(TERM_W'({1'b0, i_weight}));
    assign w_term  = w_hit ? t_term'(w_pos_x * w_wgt_x) : '0;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_hit  <= w_hit;
            r_term <= w_term;
        end
    end

    assign o_hit  = r_hit;
    assign o_term = r_term;

endmodule

// File: src/lspd_merge.sv
// Merge stage: sums the lane terms, counts active lanes and totals the
// calibration samples. Depends on lspd_pkg.
module lspd_merge (
    input  logic                   i_clk,
    input  logic                   i_load,
    input  logic                   i_hit  [lspd_pkg::N_LANES],
    input  lspd_pkg::t_term        i_term [lspd_pkg::N_LANES],
    input  lspd_pkg::t_sample      i_smp  [lspd_pkg::N_LANES],
    output logic signed [lspd_pkg::SUM_W-1:0] o_sum,
    output logic [lspd_pkg::CNT_W-1:0]        o_cnt,
    output logic [lspd_pkg::CAL_W-1:0]        o_cal
);
    import lspd_pkg::*;

    logic signed [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0]        n_cnt;
    logic [CAL_W-1:0]        n_cal;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_cnt;
    logic [CAL_W-1:0]        r_cal;

    always_comb begin
        n_sum = '0;
        n_cnt = '0;
        n_cal = '0;
        for (int i = 0; i < N_LANES; i++) begin
            n_sum = n_sum + SUM_W'(i_term[i]);
            n_cnt = n_cnt + CNT_W'(i_hit[i]);
            if (LANE_CAL[i]) begin
                n_cal = n_cal + CAL_W'(i_smp[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
            r_cal <= n_cal;
        end
    end

    assign o_sum = r_sum;
    assign o_cnt = r_cnt;
    assign o_cal = r_cal;

endmodule

// File: src/lspd_div.sv
// Iterative restoring divider, two quotient bits per cycle, dividing the
// line position sum by the active lane count. Depends on lspd_pkg.
module lspd_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lspd_pkg::DIV_W-1:0]  i_dividend,
    input  logic [lspd_pkg::CNT_W-1:0]  i_divisor,
    output logic                        o_busy,
    output logic [lspd_pkg::DIV_W-1:0]  o_quot
);
    import lspd_pkg::*;

    logic                r_busy;
    logic [DIV_CW-1:0]   r_cnt;
    logic [CNT_W-1:0]    r_dvs;
    logic [CNT_W-1:0]    r_rem;
    logic [DIV_PW-1:0]   r_quo;
    logic [CNT_W-1:0]    n_rem;
    logic [DIV_PW-1:0]   n_quo;

    always_comb begin
        logic [CNT_W:0] t;
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < 2; k++) begin
            t = {n_rem, n_quo[DIV_PW-1]};
            if (t >= {1'b0, r_dvs}) begin
                n_rem = CNT_W'(t - {1'b0, r_dvs});
                n_quo = {n_quo[DIV_PW-2:0], 1'b1};
            end else begin
                n_rem = t[CNT_W-1:0];
                n_quo = {n_quo[DIV_PW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CW'(DIV_STEPS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - DIV_CW'(1);
            if (r_cnt == DIV_CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvs <= i_divisor;
            r_rem <= '0;
            r_quo <= DIV_PW'(i_dividend);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo[DIV_W-1:0];

endmodule

// File: src/lspd_pd.sv
// PD correction and motor command stage: gain products, correction sum,
// base speed mixing and duty/direction saturation. Depends on lspd_pkg.
module lspd_pd (
    input  logic                                   i_clk,
    input  lspd_pkg::t_pd_ctrl                     i_ctrl,
    input  lspd_pkg::t_err                         i_err,
    input  lspd_pkg::t_err                         i_prev,
    input  logic [lspd_pkg::GAIN_BITS-1:0]         i_prop,
    input  logic [lspd_pkg::GAIN_BITS-1:0]         i_deriv,
    input  logic signed [lspd_pkg::SPEED_BITS-1:0] i_base,
    output logic signed [lspd_pkg::CORR_W-1:0]     o_corr,
    output logic [lspd_pkg::DUTY_W-1:0]            o_left_duty,
    output logic [lspd_pkg::DIR_W-1:0]             o_left_dir,
    output logic [lspd_pkg::DUTY_W-1:0]            o_right_duty,
    output logic [lspd_pkg::DIR_W-1:0]             o_right_dir
);
    import lspd_pkg::*;

    logic signed [CORR_W-1:0] w_err_x;
    logic signed [CORR_W-1:0] w_dlt_x;
    logic signed [CORR_W-1:0] w_kp_x;
    logic signed [CORR_W-1:0] w_kd_x;
    logic signed [ERR_W:0]    w_delta;
    logic signed [CORR_W-1:0] r_p;
    logic signed [CORR_W-1:0] r_d;
    logic signed [CORR_W-1:0] w_corr;
    logic signed [CMD_W-1:0]  w_base_x;
    logic signed [CMD_W-1:0]  w_corr_x;
    logic signed [CORR_W-1:0] r_corr;
    logic signed [CMD_W-1:0]  r_lcmd;
    logic signed [CMD_W-1:0]  r_rcmd;
    logic [CMD_W-1:0]         w_lmag;
    logic [CMD_W-1:0]         w_rmag;

    assign w_delta = (ERR_W+1)'(i_err) - (ERR_W+1)'(i_prev);
    assign w_err_x = CORR_W'(i_err);
    assign w_dlt_x = CORR_W'(w_delta);
    assign w_kp_x  = $signed(CORR_W'({1'b0, i_prop}));
    assign w_kd_x  = $signed(CORR_W'({1'b0, i_deriv}));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_p <= CORR_W'(w_kp_x * w_err_x);
            r_d <= CORR_W'(w_kd_x * w_dlt_x);
        end
    end

    assign w_corr   = r_p + r_d;
    assign w_base_x = CMD_W'(i_base);
    assign w_corr_x = CMD_W'(w_corr);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmd) begin
            r_corr <= w_corr;
            r_lcmd <= w_base_x + w_corr_x;
            r_rcmd <= w_base_x - w_corr_x;
        end
    end

    // magnitude and direction of each motor command, duty clipped
    assign w_lmag = r_lcmd[CMD_W-1] ? CMD_W'(-r_lcmd) : CMD_W'(r_lcmd);
    assign w_rmag = r_rcmd[CMD_W-1] ? CMD_W'(-r_rcmd) : CMD_W'(r_rcmd);

    always_comb begin
        o_left_duty  = (w_lmag > CMD_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                   : w_lmag[DUTY_W-1:0];
        o_right_duty = (w_rmag > CMD_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX)
                                                   : w_rmag[DUTY_W-1:0];
        if (r_lcmd == '0) begin
            o_left_dir = DIR_STOP;
        end else if (r_lcmd[CMD_W-1]) begin
            o_left_dir = DIR_REV;
        end else begin
            o_left_dir = DIR_FWD;
        end
        if (r_rcmd == '0) begin
            o_right_dir = DIR_STOP;
        end else if (r_rcmd[CMD_W-1]) begin
            o_right_dir = DIR_REV;
        end else begin
            o_right_dir = DIR_FWD;
        end
    end

    assign o_corr = r_corr;

endmodule
